/* src/v3a_pkg.sv */
// shared operation codes and types for the three-lane vector alu
package v3a_pkg;

	typedef logic [3:0] op_t;

	localparam op_t OP_ADD   = 4'd0;
	localparam op_t OP_SUB   = 4'd1;
	localparam op_t OP_MUL   = 4'd2;
	localparam op_t OP_DIV   = 4'd3;
	localparam op_t OP_ADDS  = 4'd4;
	localparam op_t OP_SUBS  = 4'd5;
	localparam op_t OP_MULS  = 4'd6;
	localparam op_t OP_DIVS  = 4'd7;
	localparam op_t OP_DOT   = 4'd8;
	localparam op_t OP_CROSS = 4'd9;
	localparam op_t OP_ROTR  = 4'd10;
	localparam op_t OP_ROTL  = 4'd11;
	localparam op_t OP_EQUAL = 4'd12;

endpackage

/* src/vector3_alu.sv */
// top level of the three-lane fixed point vector alu
// Three-lane vector ALU on signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction
// bits, Q16.16 by default). One item enters per clock while in_ready is high, and
// every item takes the same path whatever the operation; its length is set by
// the per-lane dividers, which resolve one quotient bit per pipeline stage.
// Results come out in order. The whole pipeline holds while a result waits at
// the output, so in_ready is low only when out_valid is high and out_ready low.
module vector3_alu #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  v3a_pkg::op_t                 operation,
	input  logic signed [DATA_WIDTH-1:0] ax,
	input  logic signed [DATA_WIDTH-1:0] ay,
	input  logic signed [DATA_WIDTH-1:0] az,
	input  logic signed [DATA_WIDTH-1:0] bx,
	input  logic signed [DATA_WIDTH-1:0] by,
	input  logic signed [DATA_WIDTH-1:0] bz,
	input  logic signed [DATA_WIDTH-1:0] scalar,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] rx,
	output logic signed [DATA_WIDTH-1:0] ry,
	output logic signed [DATA_WIDTH-1:0] rz,
	output logic signed [DATA_WIDTH-1:0] dot_result,
	output logic                         equal,
	output logic                         saturated,
	output logic                         divide_by_zero
);
	import v3a_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int NB    = DATA_WIDTH + FRAC_BITS;
	localparam int DEPTH = NB + 3;

	logic [DEPTH-1:0] vld_q;
	logic             advance;

	assign advance   = !vld_q[DEPTH-1] || out_ready;
	assign in_ready  = advance;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	logic signed [W-1:0] av [3];
	logic signed [W-1:0] bv [3];
	logic                scal, is_cross;

	assign scal  = (operation == OP_ADDS) || (operation == OP_SUBS) ||
		(operation == OP_MULS) || (operation == OP_DIVS);
	assign is_cross = operation == OP_CROSS;
	assign av[0] = ax;
	assign av[1] = ay;
	assign av[2] = az;
	assign bv[0] = scal ? scalar : bx;
	assign bv[1] = scal ? scalar : by;
	assign bv[2] = scal ? scalar : bz;

	op_t                 op_s1;
	logic signed [W-1:0] a_s1   [3];
	logic signed [W-1:0] b_s1   [3];
	logic signed [W-1:0] m0a_s1 [3];
	logic signed [W-1:0] m0b_s1 [3];
	logic signed [W-1:0] m1a_s1 [3];
	logic signed [W-1:0] m1b_s1 [3];
	logic signed [W-1:0] pass_s1[3];

	logic signed [W-1:0] val_s3  [3];
	logic                sat_s3  [3];
	logic                eq_s3   [3];
	logic signed [2*W:0] diff_s3 [3];
	logic signed [W-1:0] div_val [3];
	logic                div_sat [3];
	logic                div_dz  [3];
	op_t                 op_s2, op_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1 <= operation;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int N1 = (i + 1) % 3;
		localparam int N2 = (i + 2) % 3;

		// cross lane i takes a[i+1]*b[i+2] - a[i+2]*b[i+1]
		always_ff @(posedge clk) begin
			if (advance) begin
				a_s1[i]    <= av[i];
				b_s1[i]    <= bv[i];
				m0a_s1[i]  <= is_cross ? av[N1] : av[i];
				m0b_s1[i]  <= is_cross ? bv[N2] : bv[i];
				m1a_s1[i]  <= is_cross ? av[N2] : '0;
				m1b_s1[i]  <= is_cross ? bv[N1] : '0;
				pass_s1[i] <= (operation == OP_ROTR) ? av[N2] :
					(operation == OP_ROTL) ? av[N1] : '0;
			end
		end

		v3a_lane #(.W(W), .F(FRAC_BITS)) u_lane (
			.clk     (clk),
			.advance (advance),
			.op      (op_s1),
			.a       (a_s1[i]),
			.b       (b_s1[i]),
			.m0a     (m0a_s1[i]),
			.m0b     (m0b_s1[i]),
			.m1a     (m1a_s1[i]),
			.m1b     (m1b_s1[i]),
			.pass    (pass_s1[i]),
			.val_s3  (val_s3[i]),
			.sat_s3  (sat_s3[i]),
			.eq_s3   (eq_s3[i]),
			.diff_s3 (diff_s3[i]),
			.div_val (div_val[i]),
			.div_sat (div_sat[i]),
			.div_dz  (div_dz[i])
		);
	end

	v3a_merge #(.W(W), .F(FRAC_BITS)) u_merge (
		.clk            (clk),
		.advance        (advance),
		.op_s3          (op_s3),
		.val_s3         (val_s3),
		.sat_s3         (sat_s3),
		.eq_s3          (eq_s3),
		.diff_s3        (diff_s3),
		.div_val        (div_val),
		.div_sat        (div_sat),
		.div_dz         (div_dz),
		.rx             (rx),
		.ry             (ry),
		.rz             (rz),
		.dot_result     (dot_result),
		.equal          (equal),
		.saturated      (saturated),
		.divide_by_zero (divide_by_zero)
	);

endmodule

/* src/v3a_div.sv */
// pipelined restoring divider, one quotient bit per stage, with saturation
module v3a_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                advance,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] val,
	output logic                sat,
	output logic                dz
);
	import v3a_pkg::*;

	localparam int NB = W + F;
	localparam logic [NB:0] LIM = (NB+1)'(1) << (W - 1);
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]  ua, ub;
	logic [NB-1:0] num0;

	// remainder, numerator bits still to come shifted up, quotient filling from below
	logic [W-1:0]  rem_s  [1:NB];
	logic [NB-1:0] nq_s   [1:NB];
	logic [W-1:0]  ub_s   [1:NB];
	logic          neg_s  [1:NB];
	logic          zero_s [1:NB];
	logic          an_s   [1:NB];

	logic [W-1:0]  val_q;
	logic          sat_q, dz_q;

	assign ua   = a[W-1] ? W'(-a) : W'(a);
	assign ub   = b[W-1] ? W'(-b) : W'(b);
	assign num0 = NB'(ua) << F;

	for (genvar k = 0; k < NB; k++) begin : g_iter
		logic [W-1:0]  rem_in, ub_in;
		logic [NB-1:0] nq_in;
		logic          neg_in, zero_in, an_in;
		logic [W:0]    trial, trial_sub;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign nq_in   = num0;
			assign ub_in   = ub;
			assign neg_in  = a[W-1] ^ b[W-1];
			assign zero_in = (b == '0);
			assign an_in   = a[W-1];
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign nq_in   = nq_s[k];
			assign ub_in   = ub_s[k];
			assign neg_in  = neg_s[k];
			assign zero_in = zero_s[k];
			assign an_in   = an_s[k];
		end

		assign trial     = {rem_in, nq_in[NB-1]};
		assign ge        = trial >= {1'b0, ub_in};
		assign trial_sub = trial - {1'b0, ub_in};

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k+1]  <= ge ? trial_sub[W-1:0] : trial[W-1:0];
				nq_s[k+1]   <= {nq_in[NB-2:0], ge};
				ub_s[k+1]   <= ub_in;
				neg_s[k+1]  <= neg_in;
				zero_s[k+1] <= zero_in;
				an_s[k+1]   <= an_in;
			end
		end
	end

	logic [NB:0] q_ext;
	logic        over;

	assign q_ext = {1'b0, nq_s[NB]};
	assign over  = neg_s[NB] ? (q_ext > LIM) : (q_ext > LIM - 1'b1);

	always_ff @(posedge clk) begin
		if (advance) begin
			priority if (zero_s[NB]) begin
				val_q <= an_s[NB] ? SMIN : SMAX;
				sat_q <= 1'b0;
				dz_q  <= 1'b1;
			end else if (over) begin
				val_q <= neg_s[NB] ? SMIN : SMAX;
				sat_q <= 1'b1;
				dz_q  <= 1'b0;
			end else begin
				val_q <= neg_s[NB] ? W'(-nq_s[NB][W-1:0]) : nq_s[NB][W-1:0];
				sat_q <= 1'b0;
				dz_q  <= 1'b0;
			end
		end
	end

	assign val = val_q;
	assign sat = sat_q;
	assign dz  = dz_q;

endmodule

/* src/v3a_lane.sv */
// one vector lane: add, multiply and cross terms, plus its own divider
module v3a_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                 clk,
	input  logic                 advance,
	input  v3a_pkg::op_t         op,
	input  logic signed [W-1:0]  a,
	input  logic signed [W-1:0]  b,
	input  logic signed [W-1:0]  m0a,
	input  logic signed [W-1:0]  m0b,
	input  logic signed [W-1:0]  m1a,
	input  logic signed [W-1:0]  m1b,
	input  logic signed [W-1:0]  pass,
	output logic signed [W-1:0]  val_s3,
	output logic                 sat_s3,
	output logic                 eq_s3,
	output logic signed [2*W:0]  diff_s3,
	output logic signed [W-1:0]  div_val,
	output logic                 div_sat,
	output logic                 div_dz
);
	import v3a_pkg::*;

	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic signed [2*W-1:0] p0_s2, p1_s2;
	logic signed [W:0]     sum_s2;
	logic signed [W-1:0]   pass_s2;
	logic                  eq_s2;
	op_t                   op_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			p0_s2   <= m0a * m0b;
			p1_s2   <= m1a * m1b;
			sum_s2  <= (op == OP_SUB || op == OP_SUBS) ?
				({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
			pass_s2 <= pass;
			eq_s2   <= (op == OP_EQUAL) && (a == b);
			op_s2   <= op;
		end
	end

	logic signed [2*W:0] diff, shf;
	logic                prod_ok, add_ok;
	logic [W-1:0]        prod_v, add_v, lane_v;
	logic                lane_sat;

	assign diff    = {p0_s2[2*W-1], p0_s2} - {p1_s2[2*W-1], p1_s2};
	assign shf     = diff >>> F;
	assign prod_ok = (&shf[2*W:W-1]) | ~(|shf[2*W:W-1]);
	assign prod_v  = prod_ok ? shf[W-1:0] : (shf[2*W] ? SMIN : SMAX);
	assign add_ok  = sum_s2[W] == sum_s2[W-1];
	assign add_v   = add_ok ? sum_s2[W-1:0] : (sum_s2[W] ? SMIN : SMAX);

	always_comb begin
		unique case (op_s2)
			OP_ADD, OP_SUB, OP_ADDS, OP_SUBS: begin
				lane_v   = add_v;
				lane_sat = !add_ok;
			end
			OP_MUL, OP_MULS, OP_CROSS: begin
				lane_v   = prod_v;
				lane_sat = !prod_ok;
			end
			OP_ROTR, OP_ROTL: begin
				lane_v   = pass_s2;
				lane_sat = 1'b0;
			end
			default: begin
				lane_v   = '0;
				lane_sat = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			val_s3  <= lane_v;
			sat_s3  <= lane_sat;
			eq_s3   <= eq_s2;
			diff_s3 <= diff;
		end
	end

	v3a_div #(.W(W), .F(F)) u_div (
		.clk     (clk),
		.advance (advance),
		.a       (a),
		.b       (b),
		.val     (div_val),
		.sat     (div_sat),
		.dz      (div_dz)
	);

endmodule

/* src/v3a_merge.sv */
// merges lane results: dot sum, alignment with the dividers, output register
module v3a_merge #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                advance,
	input  v3a_pkg::op_t        op_s3,
	input  logic signed [W-1:0] val_s3  [3],
	input  logic                sat_s3  [3],
	input  logic                eq_s3   [3],
	input  logic signed [2*W:0] diff_s3 [3],
	input  logic signed [W-1:0] div_val [3],
	input  logic                div_sat [3],
	input  logic                div_dz  [3],
	output logic signed [W-1:0] rx,
	output logic signed [W-1:0] ry,
	output logic signed [W-1:0] rz,
	output logic signed [W-1:0] dot_result,
	output logic                equal,
	output logic                saturated,
	output logic                divide_by_zero
);
	import v3a_pkg::*;

	localparam int NB  = W + F;
	localparam int DLY = NB - 2;
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic         is_div;
		logic [W-1:0] rx;
		logic [W-1:0] ry;
		logic [W-1:0] rz;
		logic [W-1:0] dot;
		logic         eq;
		logic         sat;
	} fast_t;

	logic signed [2*W+2:0] dsum, dshf;
	logic                  dot_ok;
	logic [W-1:0]          dot_v;
	fast_t                 fast;
	fast_t                 fast_s4;
	fast_t                 dly_q [DLY];

	assign dsum   = diff_s3[0] + diff_s3[1] + diff_s3[2];
	assign dshf   = dsum >>> F;
	assign dot_ok = (&dshf[2*W+2:W-1]) | ~(|dshf[2*W+2:W-1]);
	assign dot_v  = dot_ok ? dshf[W-1:0] : (dshf[2*W+2] ? SMIN : SMAX);

	always_comb begin
		fast.is_div = (op_s3 == OP_DIV) || (op_s3 == OP_DIVS);
		fast.rx     = val_s3[0];
		fast.ry     = val_s3[1];
		fast.rz     = val_s3[2];
		fast.dot    = (op_s3 == OP_DOT) ? dot_v : '0;
		fast.eq     = eq_s3[0] & eq_s3[1] & eq_s3[2];
		fast.sat    = sat_s3[0] | sat_s3[1] | sat_s3[2] | ((op_s3 == OP_DOT) & !dot_ok);
	end

	// delay line lines the fast results up with the divider outputs
	always_ff @(posedge clk) begin
		if (advance) begin
			fast_s4  <= fast;
			dly_q[0] <= fast_s4;
			for (int i = 1; i < DLY; i++)
				dly_q[i] <= dly_q[i-1];
		end
	end

	fast_t last;
	assign last = dly_q[DLY-1];

	always_ff @(posedge clk) begin
		if (advance) begin
			if (last.is_div) begin
				rx             <= div_val[0];
				ry             <= div_val[1];
				rz             <= div_val[2];
				saturated      <= div_sat[0] | div_sat[1] | div_sat[2];
				divide_by_zero <= div_dz[0] | div_dz[1] | div_dz[2];
			end else begin
				rx             <= last.rx;
				ry             <= last.ry;
				rz             <= last.rz;
				saturated      <= last.sat;
				divide_by_zero <= 1'b0;
			end
			dot_result <= last.dot;
			equal      <= last.eq;
		end
	end

endmodule

/* src/v3a_checker.sv */
// port-level checks for the vector alu and the bind that attaches them
module v3a_checker #(
	parameter int W = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [W-1:0] rx,
	input logic signed [W-1:0] ry,
	input logic signed [W-1:0] rz,
	input logic signed [W-1:0] dot_result,
	input logic                equal,
	input logic                saturated,
	input logic                divide_by_zero
);

	// an equality result carries no vector and no dot product
	a_equal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && equal |-> rx == '0 && ry == '0 && rz == '0 &&
			dot_result == '0 && !saturated && !divide_by_zero)
		else $error("equal result with other fields set");

	// a result flagged divide by zero never has a dot product or equality
	a_div_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> dot_result == '0 && !equal)
		else $error("divide by zero flagged outside a division");

	// input side is open whenever no result waits
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(dot_result) &&
			$stable(saturated))
		else $error("result changed while stalled");

endmodule

bind vector3_alu v3a_checker #(.W(DATA_WIDTH)) u_v3a_checker (.*);
